FILE: sv/terminal_local_option_order_parser_core_defines.svh
// assertion macros shared by the checker
`ifndef TERMINAL_LOCAL_OPTION_ORDER_PARSER_CORE_DEFINES_SVH
`define TERMINAL_LOCAL_OPTION_ORDER_PARSER_CORE_DEFINES_SVH

// same-cycle implication
`define TLOOP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tloop same-cycle check failed");

// next-cycle implication
`define TLOOP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tloop next-cycle check failed");

`endif

FILE: sv/tloop_pkg.sv
package tloop_pkg;

    localparam logic [7:0] BYTE_BIAS    = 8'h40;
    localparam logic [7:0] ORDER_TABSET = 8'he3;
    localparam logic [7:0] FLAGS_RESET  = 8'h22;

    localparam logic [7:0] ORD_APL_ON    = 8'ha0;
    localparam logic [7:0] ORD_APL_OFF   = 8'h61;
    localparam logic [7:0] ORD_NULL_ON   = 8'hd5;
    localparam logic [7:0] ORD_NULL_OFF  = 8'h95;
    localparam logic [7:0] ORD_ZONES_ON  = 8'ha9;
    localparam logic [7:0] ORD_ZONES_OFF = 8'he9;
    localparam logic [7:0] ORD_ENTER_ON  = 8'h85;
    localparam logic [7:0] ORD_ENTER_OFF = 8'hc5;
    localparam logic [7:0] ORD_CFTAB_ON  = 8'h83;
    localparam logic [7:0] ORD_CFTAB_OFF = 8'hc3;
    localparam logic [7:0] ORD_PACE_ON   = 8'hd7;
    localparam logic [7:0] ORD_PACE_OFF  = 8'h97;
    localparam logic [7:0] ORD_ALPHA_ON  = 8'ha5;
    localparam logic [7:0] ORD_ALPHA_OFF = 8'he5;
    localparam logic [7:0] ORD_WRAP_ON   = 8'ha6;
    localparam logic [7:0] ORD_WRAP_OFF  = 8'he6;

    localparam logic [2:0] FLAG_APL   = 3'd0;
    localparam logic [2:0] FLAG_NULL  = 3'd1;
    localparam logic [2:0] FLAG_ZONES = 3'd2;
    localparam logic [2:0] FLAG_ENTER = 3'd3;
    localparam logic [2:0] FLAG_CFTAB = 3'd4;
    localparam logic [2:0] FLAG_PACE  = 3'd5;
    localparam logic [2:0] FLAG_ALPHA = 3'd6;
    localparam logic [2:0] FLAG_WRAP  = 3'd7;

    localparam logic [1:0] PH_ORDER  = 2'd0;
    localparam logic [1:0] PH_HOME   = 2'd1;
    localparam logic [1:0] PH_MARGIN = 2'd2;
    localparam logic [1:0] PH_TABS   = 2'd3;

    typedef struct packed {
        logic       hit_flag;
        logic [2:0] flag_bit;
        logic       flag_val;
        logic       tabset;
    } t_order;

    typedef struct packed {
        logic [7:0] flags;
        logic [4:0] home;
        logic [6:0] margin;
        logic       tab;
        logic       done;
    } t_result;

    function automatic t_order decode_order(logic [7:0] b);
        t_order d;
        d = '0;
        unique case (b)
            ORD_APL_ON:    d = '{1'b1, FLAG_APL,   1'b1, 1'b0};
            ORD_APL_OFF:   d = '{1'b1, FLAG_APL,   1'b0, 1'b0};
            ORD_NULL_ON:   d = '{1'b1, FLAG_NULL,  1'b1, 1'b0};
            ORD_NULL_OFF:  d = '{1'b1, FLAG_NULL,  1'b0, 1'b0};
            ORD_ZONES_ON:  d = '{1'b1, FLAG_ZONES, 1'b1, 1'b0};
            ORD_ZONES_OFF: d = '{1'b1, FLAG_ZONES, 1'b0, 1'b0};
            ORD_ENTER_ON:  d = '{1'b1, FLAG_ENTER, 1'b1, 1'b0};
            ORD_ENTER_OFF: d = '{1'b1, FLAG_ENTER, 1'b0, 1'b0};
            ORD_CFTAB_ON:  d = '{1'b1, FLAG_CFTAB, 1'b1, 1'b0};
            ORD_CFTAB_OFF: d = '{1'b1, FLAG_CFTAB, 1'b0, 1'b0};
            ORD_PACE_ON:   d = '{1'b1, FLAG_PACE,  1'b1, 1'b0};
            ORD_PACE_OFF:  d = '{1'b1, FLAG_PACE,  1'b0, 1'b0};
            ORD_ALPHA_ON:  d = '{1'b1, FLAG_ALPHA, 1'b1, 1'b0};
            ORD_ALPHA_OFF: d = '{1'b1, FLAG_ALPHA, 1'b0, 1'b0};
            ORD_WRAP_ON:   d = '{1'b1, FLAG_WRAP,  1'b1, 1'b0};
            ORD_WRAP_OFF:  d = '{1'b1, FLAG_WRAP,  1'b0, 1'b0};
            ORDER_TABSET:  d = '{1'b0, 3'd0,       1'b0, 1'b1};
            default:       d = '0;
        endcase
        return d;
    endfunction

endpackage

FILE: sv/terminal_local_option_order_parser_core.sv
// local-option order parser
// input channel: one stream byte per transaction (i_valid / o_stall), with the
// end-of-data mark and a column whose tab-stop bit is reported
// output channel: one result per input transaction (o_valid / i_stall) with the
// eight option flags, home row, left margin, queried tab bit and order-complete
// each result is registered, into the skid register while the output waits
// throughput: one byte per cycle while o_stall is low; all parse state
// updates in the accepting cycle; the tab-stop table lives in flip-flops
// and is cleared by the tab-set order
// a result register plus one skid register sit between the two channels, so a
// byte is still taken while one result waits; o_stall rises only once both are
// full and the receiver keeps i_stall high
// reset (synchronous, active low) empties both result registers, returns the
// parser to the order phase, sets null processing and pacing, clears home and
// margin, and loads tab stops at every eighth column
module terminal_local_option_order_parser_core #(
    parameter int TAB_COLUMNS = 80,
    parameter int SCREEN_ROWS = 24,
    parameter int MAX_TABS    = 28
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_data,
    input  logic [6:0] i_query_column,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_apl_mode,
    output logic       o_null_processing,
    output logic       o_zones_mode,
    output logic       o_enter_newline,
    output logic       o_column_field_tab,
    output logic       o_pacing,
    output logic       o_alpha_in_numeric,
    output logic       o_word_wrap,
    output logic [4:0] o_home_row,
    output logic [6:0] o_left_margin,
    output logic       o_tab_at_query,
    output logic       o_order_complete
);

    localparam int TW = (TAB_COLUMNS > 1) ? $clog2(TAB_COLUMNS) : 1;

    logic [1:0]             r_phase, n_phase;
    logic [4:0]             r_taken, n_taken;
    logic [7:0]             r_flags, n_flags;
    logic [4:0]             r_home, n_home;
    logic [6:0]             r_margin, n_margin;
    logic [TAB_COLUMNS-1:0] r_tabs, n_tabs;

    logic                   r_out_valid, r_skid_valid;
    tloop_pkg::t_result     r_out, r_skid, n_res;

    logic                   accept, take;
    logic [7:0]             biased;
    logic                   above_bias, home_ok, col_ok, dispatch;
    logic [4:0]             taken_inc;
    tloop_pkg::t_order      ord;

    assign accept     = i_valid && !r_skid_valid;
    assign take       = r_out_valid && !i_stall;
    assign o_stall    = r_skid_valid;

    assign biased     = i_data_byte - tloop_pkg::BYTE_BIAS;
    assign above_bias = i_data_byte >= tloop_pkg::BYTE_BIAS;
    assign home_ok    = above_bias && (biased < 8'(SCREEN_ROWS));
    assign col_ok     = above_bias && ({1'b0, biased} < 9'(TAB_COLUMNS));
    assign taken_inc  = r_taken + 5'd1;
    assign ord        = tloop_pkg::decode_order(i_data_byte);
    assign dispatch   = (r_phase == tloop_pkg::PH_ORDER) ||
                        ((r_phase == tloop_pkg::PH_TABS) && !col_ok);

    always_comb begin
        n_phase  = tloop_pkg::PH_ORDER;
        n_taken  = r_taken;
        n_flags  = r_flags;
        n_home   = r_home;
        n_margin = r_margin;
        n_tabs   = r_tabs;
        n_res    = '0;

        unique case (r_phase)
            tloop_pkg::PH_HOME: begin
                if (home_ok) begin
                    n_home = biased[4:0];
                end
                if (!home_ok || i_end_of_data) begin
                    n_res.done = 1'b1;
                end else begin
                    n_phase = tloop_pkg::PH_MARGIN;
                end
            end
            tloop_pkg::PH_MARGIN: begin
                if (col_ok) begin
                    n_margin = biased[6:0];
                end
                if (!col_ok || i_end_of_data) begin
                    n_res.done = 1'b1;
                end else begin
                    n_taken = '0;
                    n_phase = tloop_pkg::PH_TABS;
                end
            end
            tloop_pkg::PH_TABS: begin
                n_res.done = 1'b1;
                if (col_ok) begin
                    n_tabs[biased[TW-1:0]] = 1'b1;
                    n_taken = taken_inc;
                    if (taken_inc < 5'(MAX_TABS) && !i_end_of_data) begin
                        n_res.done = 1'b0;
                        n_phase    = tloop_pkg::PH_TABS;
                    end
                end
            end
            default: begin
            end
        endcase

        // order byte, also a rejected tab byte
        if (dispatch) begin
            if (ord.hit_flag) begin
                n_flags[ord.flag_bit] = ord.flag_val;
            end
            if (ord.tabset) begin
                n_tabs = '0;
                if (!i_end_of_data) begin
                    n_phase = tloop_pkg::PH_HOME;
                end
            end
            n_res.done = (r_phase == tloop_pkg::PH_TABS) ||
                         !(ord.tabset && !i_end_of_data);
        end

        n_res.flags  = n_flags;
        n_res.home   = n_home;
        n_res.margin = n_margin;
        n_res.tab    = ({1'b0, i_query_column} < 8'(TAB_COLUMNS)) ?
                       n_tabs[i_query_column[TW-1:0]] : 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= tloop_pkg::PH_ORDER;
            r_taken      <= '0;
            r_flags      <= tloop_pkg::FLAGS_RESET;
            r_home       <= '0;
            r_margin     <= '0;
            for (int i = 0; i < TAB_COLUMNS; i++) begin
                r_tabs[i] <= ((i % 8) == 0);
            end
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase  <= n_phase;
                r_taken  <= n_taken;
                r_flags  <= n_flags;
                r_home   <= n_home;
                r_margin <= n_margin;
                r_tabs   <= n_tabs;
            end
            if (take || !r_out_valid) begin
                r_out_valid  <= r_skid_valid || accept;
                r_skid_valid <= 1'b0;
            end else if (accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= n_res;
            end
        end else if (accept) begin
            r_skid <= n_res;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_apl_mode         = r_out.flags[tloop_pkg::FLAG_APL];
    assign o_null_processing  = r_out.flags[tloop_pkg::FLAG_NULL];
    assign o_zones_mode       = r_out.flags[tloop_pkg::FLAG_ZONES];
    assign o_enter_newline    = r_out.flags[tloop_pkg::FLAG_ENTER];
    assign o_column_field_tab = r_out.flags[tloop_pkg::FLAG_CFTAB];
    assign o_pacing           = r_out.flags[tloop_pkg::FLAG_PACE];
    assign o_alpha_in_numeric = r_out.flags[tloop_pkg::FLAG_ALPHA];
    assign o_word_wrap        = r_out.flags[tloop_pkg::FLAG_WRAP];
    assign o_home_row         = r_out.home;
    assign o_left_margin      = r_out.margin;
    assign o_tab_at_query     = r_out.tab;
    assign o_order_complete   = r_out.done;

endmodule

FILE: sv/tloop_checker.sv
`include "terminal_local_option_order_parser_core_defines.svh"

module tloop_checker #(
    parameter int TAB_COLUMNS = 80
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_flags,
    input logic [4:0] o_home_row,
    input logic [6:0] o_left_margin,
    input logic       o_tab_at_query,
    input logic       o_order_complete
);

    // skid only fills behind a full output register
    `TLOOP_ASSERT_NOW(a_stall_needs_output, i_clk, i_rst_n, o_stall, o_valid)

    // a transaction into an empty or draining output shows up next cycle
    `TLOOP_ASSERT_NEXT(a_accept_to_output, i_clk, i_rst_n, i_valid && !o_stall && !(o_valid && i_stall), o_valid)

    // stalled result holds
    `TLOOP_ASSERT_NEXT(a_stalled_result_holds, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_flags) && $stable(o_home_row) && $stable(o_left_margin) && $stable(o_tab_at_query) && $stable(o_order_complete))

    // margin is only loaded from an in-range column
    `TLOOP_ASSERT_NOW(a_margin_in_range, i_clk, i_rst_n, o_valid, {1'b0, o_left_margin} < 8'(TAB_COLUMNS))

endmodule

bind terminal_local_option_order_parser_core tloop_checker #(
    .TAB_COLUMNS(TAB_COLUMNS)
) u_tloop_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_flags          ({o_word_wrap, o_alpha_in_numeric, o_pacing, o_column_field_tab,
                        o_enter_newline, o_zones_mode, o_null_processing, o_apl_mode}),
    .o_home_row       (o_home_row),
    .o_left_margin    (o_left_margin),
    .o_tab_at_query   (o_tab_at_query),
    .o_order_complete (o_order_complete)
);
